### src/plm_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; the top level and the checker in src/ refer to this package by scoped names.
package plm_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int ACTION_W = 2;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 8;
   localparam int CNT_W    = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_LOCATE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS,
      S_INS_WAIT,
      S_PUT,
      S_DEL,
      S_DEL_WAIT,
      S_RD,
      S_RD_WAIT,
      S_LOC,
      S_LOC_LAST
   } state_type;

endpackage

### src/plm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module plm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/positional_list_engine_top.sv
// Positional list engine: byte list in one RAM plus a length register. Uses plm_pkg, plm_ram.
// A rejected request or a locate on an empty list is answered from idle; an append writes directly,
// a read waits for the registered RAM data, and insert, delete and locate walk over the stored elements.
// Throughput: one request at a time; the walk over the RAM, one element per cycle, sets it.
// Reset (synchronous, active high) empties the list; RAM contents stay undefined.
// The result strobe lasts one cycle and the receiver cannot stall it.
module positional_list_engine_top #(
   parameter int CAPACITY = plm_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [plm_pkg::ACTION_W-1:0] req_action,
   input  logic [plm_pkg::POS_W-1:0]    req_position,
   input  logic [plm_pkg::VAL_W-1:0]    req_item_value,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [plm_pkg::VAL_W-1:0]    rsp_read_value,
   output logic [plm_pkg::POS_W-1:0]    rsp_found_position,
   output logic [plm_pkg::CNT_W-1:0]    rsp_count,
   output logic                         rsp_is_empty
);

   // AW addresses the RAM, LW holds a length up to CAPACITY, CW is a compare width
   // wide enough for both the 7-bit position and the length plus one.
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > plm_pkg::POS_W) ? LW : plm_pkg::POS_W) + 1;

   plm_pkg::state_type state_ff, state_in;

   logic [LW-1:0]               len_ff, len_in;
   logic [AW-1:0]               tgt_ff, tgt_in;     // position - 1 of the request
   logic [AW-1:0]               ptr_ff, ptr_in;     // RAM read address of the walk
   logic [plm_pkg::VAL_W-1:0]   val_ff, val_in;
   logic                        mv_valid_ff, mv_valid_in;  // element in flight to be moved
   logic [AW-1:0]               mv_addr_ff, mv_addr_in;
   logic                        cap_ff, cap_in;     // read data is the removed element
   logic [plm_pkg::VAL_W-1:0]   hold_ff, hold_in;
   logic                        cmp_valid_ff, cmp_valid_in;  // read data is a locate candidate
   logic [AW-1:0]               cmp_idx_ff, cmp_idx_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [plm_pkg::VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [plm_pkg::POS_W-1:0]   rsp_found_ff, rsp_found_in;

   // RAM ports
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [plm_pkg::VAL_W-1:0]   wr_data;
   logic [plm_pkg::VAL_W-1:0]   rd_data;

   // Request decode
   logic                        accept;
   logic [CW-1:0]               pos_ext, len_ext, pos_m1;
   logic [LW-1:0]               len_m1;
   logic                        ins_ok, pos_ok, append, list_empty;
   logic                        ptr_at_tgt, ptr_at_last, hit;
   logic [CW-1:0]               found_wide, len_wide;

   assign accept     = start && (state_ff == plm_pkg::S_IDLE);
   assign pos_ext    = CW'(req_position);
   assign len_ext    = CW'(len_ff);
   assign pos_m1     = pos_ext - CW'(1);
   assign len_m1     = len_ff - LW'(1);
   assign list_empty = (len_ff == '0);

   // Insert may go one past the end unless the list is full; delete and read stay inside.
   assign ins_ok = (pos_ext != '0) && (pos_ext <= len_ext + CW'(1))
                   && (len_ext < CW'(CAPACITY));
   assign pos_ok = (pos_ext != '0) && (pos_ext <= len_ext);
   assign append = (pos_ext == len_ext + CW'(1));

   assign ptr_at_tgt  = (ptr_ff == tgt_ff);
   assign ptr_at_last = (ptr_ff == len_m1[AW-1:0]);
   assign hit         = cmp_valid_ff && (rd_data == val_ff);
   assign found_wide  = CW'(cmp_idx_ff) + CW'(1);
   assign len_wide    = CW'(len_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plm_pkg::S_IDLE: begin
            if (accept) begin
               unique case (plm_pkg::action_type'(req_action))
                  plm_pkg::ACT_INSERT: begin
                     if (ins_ok) begin
                        state_in = append ? plm_pkg::S_PUT : plm_pkg::S_INS;
                     end
                  end
                  plm_pkg::ACT_DELETE: begin
                     if (pos_ok) begin
                        state_in = plm_pkg::S_DEL;
                     end
                  end
                  plm_pkg::ACT_READ: begin
                     if (pos_ok) begin
                        state_in = plm_pkg::S_RD;
                     end
                  end
                  plm_pkg::ACT_LOCATE: begin
                     if (!list_empty) begin
                        state_in = plm_pkg::S_LOC;
                     end
                  end
               endcase
            end
         end
         plm_pkg::S_INS: begin
            if (ptr_at_tgt) begin
               state_in = plm_pkg::S_INS_WAIT;
            end
         end
         plm_pkg::S_INS_WAIT: state_in = plm_pkg::S_PUT;
         plm_pkg::S_PUT:      state_in = plm_pkg::S_IDLE;
         plm_pkg::S_DEL: begin
            if (ptr_at_last) begin
               state_in = plm_pkg::S_DEL_WAIT;
            end
         end
         plm_pkg::S_DEL_WAIT: state_in = plm_pkg::S_IDLE;
         plm_pkg::S_RD:       state_in = plm_pkg::S_RD_WAIT;
         plm_pkg::S_RD_WAIT:  state_in = plm_pkg::S_IDLE;
         plm_pkg::S_LOC: begin
            if (hit) begin
               state_in = plm_pkg::S_IDLE;
            end else if (ptr_at_last) begin
               state_in = plm_pkg::S_LOC_LAST;
            end
         end
         plm_pkg::S_LOC_LAST: state_in = plm_pkg::S_IDLE;
         default:             state_in = plm_pkg::S_IDLE;
      endcase
   end

   // Datapath and result
   always_comb begin
      len_in       = len_ff;
      tgt_in       = tgt_ff;
      ptr_in       = ptr_ff;
      val_in       = val_ff;
      mv_valid_in  = 1'b0;
      mv_addr_in   = mv_addr_ff;
      cap_in       = 1'b0;
      hold_in      = cap_ff ? rd_data : hold_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;

      unique case (state_ff)
         plm_pkg::S_IDLE: begin
            if (accept) begin
               // Latch the request; the target index is only used once validated.
               val_in = req_item_value;
               tgt_in = pos_m1[AW-1:0];
               unique case (plm_pkg::action_type'(req_action))
                  plm_pkg::ACT_INSERT: begin
                     // Walk down from the last element, moving each one up a slot.
                     ptr_in = len_m1[AW-1:0];
                     if (!ins_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                        rsp_value_in = '0;
                        rsp_found_in = '0;
                     end
                  end
                  plm_pkg::ACT_DELETE,
                  plm_pkg::ACT_READ: begin
                     ptr_in = pos_m1[AW-1:0];
                     if (!pos_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b0;
                        rsp_value_in = '0;
                        rsp_found_in = '0;
                     end
                  end
                  plm_pkg::ACT_LOCATE: begin
                     ptr_in = '0;
                     if (list_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b1;
                        rsp_value_in = '0;
                        rsp_found_in = '0;
                     end
                  end
               endcase
            end
         end
         plm_pkg::S_INS: begin
            mv_valid_in = 1'b1;
            mv_addr_in  = ptr_ff + AW'(1);
            if (!ptr_at_tgt) begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         plm_pkg::S_INS_WAIT: begin
            // Last moved element is written this cycle; the new value follows.
         end
         plm_pkg::S_PUT: begin
            len_in       = len_ff + LW'(1);
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_value_in = '0;
            rsp_found_in = '0;
         end
         plm_pkg::S_DEL: begin
            // First read is the removed element; the rest move down one slot.
            if (ptr_at_tgt) begin
               cap_in = 1'b1;
            end else begin
               mv_valid_in = 1'b1;
               mv_addr_in  = ptr_ff - AW'(1);
            end
            if (!ptr_at_last) begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         plm_pkg::S_DEL_WAIT: begin
            len_in       = len_ff - LW'(1);
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_value_in = cap_ff ? rd_data : hold_ff;
            rsp_found_in = '0;
         end
         plm_pkg::S_RD: begin
            // Read issued at ptr; data arrives next cycle.
         end
         plm_pkg::S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_value_in = rd_data;
            rsp_found_in = '0;
         end
         plm_pkg::S_LOC: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_value_in = '0;
               rsp_found_in = found_wide[plm_pkg::POS_W-1:0];
            end else begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = ptr_ff;
               if (!ptr_at_last) begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
         end
         plm_pkg::S_LOC_LAST: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_value_in = '0;
            rsp_found_in = hit ? found_wide[plm_pkg::POS_W-1:0] : '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plm_pkg::S_IDLE;
         len_ff       <= '0;
         mv_valid_ff  <= 1'b0;
         cap_ff       <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         mv_valid_ff  <= mv_valid_in;
         cap_ff       <= cap_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      ptr_ff       <= ptr_in;
      val_ff       <= val_in;
      mv_addr_ff   <= mv_addr_in;
      hold_ff      <= hold_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
   end

   // Moves never collide with the read: insert writes above the read address,
   // delete writes below it. The new value goes in after the last move.
   assign wr_en   = mv_valid_ff || (state_ff == plm_pkg::S_PUT);
   assign wr_addr = mv_valid_ff ? mv_addr_ff : tgt_ff;
   assign wr_data = mv_valid_ff ? rd_data : val_ff;

   plm_ram #(
      .WIDTH (plm_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign busy               = (state_ff != plm_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_read_value     = rsp_value_ff;
   assign rsp_found_position = rsp_found_ff;
   // Length holds steady through the result cycle.
   assign rsp_count          = len_wide[plm_pkg::CNT_W-1:0];
   assign rsp_is_empty       = list_empty;

endmodule

### src/plm_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
// Depends on plm_pkg.
module plm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_ok,
   input logic [plm_pkg::VAL_W-1:0]    rsp_read_value,
   input logic [plm_pkg::POS_W-1:0]    rsp_found_position,
   input logic [plm_pkg::CNT_W-1:0]    rsp_count,
   input logic                         rsp_is_empty
);

   // An accepted request is either in progress or answered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor answered");

   // Leaving busy always produces a result.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> (busy || rsp_valid))
      else $error("busy dropped without a result");

   // A result is only shown when the engine is idle again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // A located position comes with success and no read value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_found_position != '0)) |-> (rsp_ok && (rsp_read_value == '0)))
      else $error("found position with bad ok or value");

   // The empty flag agrees with the reported length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

endmodule

bind positional_list_engine_top plm_checker u_plm_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_ok             (rsp_ok),
   .rsp_read_value     (rsp_read_value),
   .rsp_found_position (rsp_found_position),
   .rsp_count          (rsp_count),
   .rsp_is_empty       (rsp_is_empty)
);

### test/tb_top.sv
// Self-checking testbench for positional_list_engine_top: drives list requests and
// checks every result against a queue-based copy of the list kept inside the bench.
// Depends on plm_pkg and the RTL under src/.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = plm_pkg::CAPACITY_DEFAULT;
   localparam int ACTION_W    = plm_pkg::ACTION_W;
   localparam int POS_W       = plm_pkg::POS_W;
   localparam int VAL_W       = plm_pkg::VAL_W;
   localparam int CNT_W       = plm_pkg::CNT_W;
   localparam int CYCLE_LIMIT = 400000;
   // longest walk is an insert at the head of a nearly full list
   localparam int SETTLE_CYCLES = CAPACITY + 16;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic              ok;
      logic [VAL_W-1:0]  read_value;
      logic [POS_W-1:0]  found_position;
      logic [CNT_W-1:0]  count;
      logic              is_empty;
   } list_result_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [ACTION_W-1:0] req_action     = '0;
   logic [POS_W-1:0]    req_position   = '0;
   logic [VAL_W-1:0]    req_item_value = '0;
   logic                busy;
   logic                rsp_valid;
   logic                rsp_ok;
   logic [VAL_W-1:0]    rsp_read_value;
   logic [POS_W-1:0]    rsp_found_position;
   logic [CNT_W-1:0]    rsp_count;
   logic                rsp_is_empty;

   // bench copy of the stored list, head at index 0
   logic [VAL_W-1:0] list_shadow[$];
   // results owed by the engine, oldest first
   list_result_type  awaited_results[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  idle_off       = 1'b0;

   positional_list_engine_top #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   always #6 clock = ~clock;

   // Abort on a hang: the slowest legal run is far below this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, awaited_results.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Apply one request to the bench list and return the result it must produce.
   function automatic list_result_type predict_list_action(plm_pkg::action_type act,
                                                           logic [POS_W-1:0] pos,
                                                           logic [VAL_W-1:0] val);
      list_result_type r;
      int              n;
      int              p;
      r = '0;
      n = list_shadow.size();
      p = int'(pos);
      case (act)
         plm_pkg::ACT_INSERT: begin
            // reject position zero, a gap past the tail, and a full list
            if (p >= 1 && p <= n + 1 && n < CAPACITY) begin
               list_shadow.insert(p - 1, val);
               r.ok = 1'b1;
            end
         end
         plm_pkg::ACT_DELETE: begin
            if (p >= 1 && p <= n) begin
               r.read_value = list_shadow[p - 1];
               list_shadow.delete(p - 1);
               r.ok = 1'b1;
            end
         end
         plm_pkg::ACT_READ: begin
            if (p >= 1 && p <= n) begin
               r.read_value = list_shadow[p - 1];
               r.ok = 1'b1;
            end
         end
         default: begin
            // locate always succeeds; report the first match only
            r.ok = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (r.found_position == '0 && list_shadow[i] == val)
                  r.found_position = POS_W'(i + 1);
            end
         end
      endcase
      r.count    = CNT_W'(list_shadow.size());
      r.is_empty = (list_shadow.size() == 0);
      return r;
   endfunction

   // Check every strobed result against the oldest owed one.
   list_result_type seen_result;
   list_result_type owed_result;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_result = {rsp_ok, rsp_read_value, rsp_found_position, rsp_count, rsp_is_empty};
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: ok=%0b val=%0h found=%0d count=%0d empty=%0b",
                        rsp_ok, rsp_read_value, rsp_found_position, rsp_count,
                        rsp_is_empty);
         end else begin
            owed_result = awaited_results.pop_front();
            if (seen_result !== owed_result) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: ok %0b/%0b val %0h/%0h found %0d/%0d",
                            " count %0d/%0d empty %0b/%0b (expected/actual)"},
                           owed_result.ok, rsp_ok,
                           owed_result.read_value, rsp_read_value,
                           owed_result.found_position, rsp_found_position,
                           owed_result.count, rsp_count,
                           owed_result.is_empty, rsp_is_empty);
            end
         end
      end
   end

   // Drop start for a random number of cycles: mostly none, some short, a few long.
   task automatic idle_gap();
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (idle_off || roll < 65)
         gap = 0;
      else if (roll < 93)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(5, 40);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Present one request at the falling edge, hold it until the engine takes it,
   // then log the result it owes. Start stays high for the caller to decide.
   task automatic send_request(plm_pkg::action_type act, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      idle_gap();
      req_action     = act;
      req_position   = pos;
      req_item_value = val;
      start          = 1'b1;
      do
         @(posedge clock);
      while (busy);
      awaited_results.push_back(predict_list_action(act, pos, val));
      @(negedge clock);
   endtask

   // Hold off new requests until every owed result has come back.
   task automatic wait_for_drain();
      start = 1'b0;
      while (awaited_results.size() != 0)
         @(negedge clock);
   endtask

   // One random request; ins_w and del_w steer the list toward growing or shrinking.
   task automatic issue_random_request(int ins_w, int del_w);
      int                   n;
      int                   roll;
      plm_pkg::action_type  act;
      logic [POS_W-1:0]     pos;
      logic [VAL_W-1:0]     val;
      n    = list_shadow.size();
      roll = $urandom_range(0, 99);
      if (roll < ins_w)
         act = plm_pkg::ACT_INSERT;
      else if (roll < ins_w + del_w)
         act = plm_pkg::ACT_DELETE;
      else if (roll < ins_w + del_w + (100 - ins_w - del_w) / 2)
         act = plm_pkg::ACT_READ;
      else
         act = plm_pkg::ACT_LOCATE;
      // mostly legal positions, some noise over the whole field
      if ($urandom_range(0, 99) < 12)
         pos = POS_W'($urandom_range(0, 127));
      else if (act == plm_pkg::ACT_INSERT)
         pos = POS_W'($urandom_range(1, n + 1));
      else
         pos = POS_W'($urandom_range(1, (n > 0) ? n : 1));
      // favor stored values for locate and a tiny alphabet for duplicates
      if (act == plm_pkg::ACT_LOCATE && n > 0 && $urandom_range(0, 99) < 60)
         val = list_shadow[$urandom_range(0, n - 1)];
      else if ($urandom_range(0, 99) < 25)
         val = VAL_W'($urandom_range(0, 3));
      else
         val = VAL_W'($urandom_range(0, 255));
      send_request(act, pos, val);
   endtask

   // Every action on an empty list, and inserts at position zero and past its end.
   task automatic test_empty_list();
      send_request(plm_pkg::ACT_READ,   7'd1,   8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd1,   8'h00);
      send_request(plm_pkg::ACT_LOCATE, 7'd0,   8'h00);
      send_request(plm_pkg::ACT_INSERT, 7'd0,   8'hA5);
      send_request(plm_pkg::ACT_INSERT, 7'd2,   8'hA5);
      send_request(plm_pkg::ACT_INSERT, 7'd127, 8'hFF);
   endtask

   // Head, middle and tail edits on a short list, duplicate values, bad positions.
   task automatic test_basic_edit();
      send_request(plm_pkg::ACT_INSERT, 7'd1, 8'hFF);
      send_request(plm_pkg::ACT_INSERT, 7'd2, 8'h00);
      send_request(plm_pkg::ACT_INSERT, 7'd1, 8'h5A);
      send_request(plm_pkg::ACT_INSERT, 7'd2, 8'h5A);
      // list is now 5A 5A FF 00
      send_request(plm_pkg::ACT_LOCATE, 7'd127, 8'h5A);
      send_request(plm_pkg::ACT_LOCATE, 7'd0,   8'h00);
      send_request(plm_pkg::ACT_LOCATE, 7'd3,   8'h77);
      send_request(plm_pkg::ACT_READ,   7'd3,   8'hFF);
      send_request(plm_pkg::ACT_READ,   7'd5,   8'h00);
      send_request(plm_pkg::ACT_READ,   7'd0,   8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd0,   8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd5,   8'h00);
      send_request(plm_pkg::ACT_INSERT, 7'd6,   8'h11);
      send_request(plm_pkg::ACT_DELETE, 7'd4,   8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd1,   8'h00);
      send_request(plm_pkg::ACT_INSERT, 7'd2,   8'h80);
      send_request(plm_pkg::ACT_DELETE, 7'd2,   8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd1,   8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd1,   8'h00);
      send_request(plm_pkg::ACT_LOCATE, 7'd1,   8'hFF);
   endtask

   // Fill to capacity at random positions, hit the full-list rejections, then drain.
   task automatic test_full_list();
      int n;
      while (list_shadow.size() < CAPACITY) begin
         n = list_shadow.size();
         send_request(plm_pkg::ACT_INSERT, POS_W'($urandom_range(1, n + 1)),
                      VAL_W'($urandom_range(0, 255)));
      end
      wait_for_drain();
      send_request(plm_pkg::ACT_INSERT, 7'd1,  8'h42);
      send_request(plm_pkg::ACT_INSERT, 7'd65, 8'h42);
      send_request(plm_pkg::ACT_INSERT, 7'd33, 8'h42);
      send_request(plm_pkg::ACT_READ,   7'd64, 8'h00);
      send_request(plm_pkg::ACT_READ,   7'd65, 8'h00);
      send_request(plm_pkg::ACT_DELETE, 7'd65, 8'h00);
      send_request(plm_pkg::ACT_LOCATE, 7'd0,  list_shadow[CAPACITY - 1]);
      send_request(plm_pkg::ACT_DELETE, 7'd64, 8'h00);
      send_request(plm_pkg::ACT_INSERT, 7'd64, 8'hC3);
      send_request(plm_pkg::ACT_DELETE, 7'd1,  8'h00);
      send_request(plm_pkg::ACT_INSERT, 7'd1,  8'h3C);
      while (list_shadow.size() > 0) begin
         n = list_shadow.size();
         send_request(plm_pkg::ACT_DELETE, POS_W'($urandom_range(1, n)), 8'h00);
      end
   endtask

   // Long random mix; phases lean toward growth, shrinkage or balance.
   task automatic test_random_mix(int item_total);
      int ins_w;
      int del_w;
      for (int i = 0; i < item_total; i++) begin
         if (i % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: begin ins_w = 50; del_w = 12; end
               1: begin ins_w = 12; del_w = 50; end
               default: begin ins_w = 30; del_w = 30; end
            endcase
         end
         // advance through stretches without any idle cycles
         idle_off = ((i / 100) % 4 == 3);
         if (i % 200 == 199)
            wait_for_drain();
         issue_random_request(ins_w, del_w);
      end
      idle_off = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_basic_edit();
      test_full_list();
      test_random_mix(800);

      // drop start, wait out owed results, then let any late strobe show up
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  awaited_results.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
